>>> hdl/lrufr_pkg.sv
// Package for the LRU frame replacer: sizes, field widths, command codes
// and register map. Used by the channel interfaces and by every RTL module but lrufr_ram.
package lrufr_pkg;

  localparam int NUM_FRAMES = 64;
  localparam int ADDR_W     = $clog2(NUM_FRAMES);
  localparam int CNT_W      = $clog2(NUM_FRAMES + 1);

  // Fixed field widths of the item and result payloads and of the capacity.
  localparam int CMD_W     = 2;
  localparam int FRAME_W   = 6;
  localparam int ECOUNT_W  = 7;
  localparam int CAP_W     = 7;

  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  // Configuration port.
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam int REG_IDX_W  = APB_ADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_CAPACITY = 1'b0;

  typedef enum logic [CMD_W-1:0] {
    CMD_VICTIM = 2'd0,
    CMD_PIN    = 2'd1,
    CMD_UNPIN  = 2'd2,
    CMD_SIZE   = 2'd3
  } cmd_t;

endpackage

>>> hdl/lrufr_if.sv
// Valid/ready channel interfaces for the LRU frame replacer: the command
// channel and the result channel. Depends on lrufr_pkg.
interface lrufr_in_if;
  import lrufr_pkg::*;
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   command;
  logic [FRAME_W-1:0] frame_index;

  modport source (output valid, command, frame_index, input ready);
  modport sink   (input valid, command, frame_index, output ready);
endinterface

interface lrufr_out_if;
  import lrufr_pkg::*;
  logic                valid;
  logic                ready;
  logic                victim_valid;
  logic [FRAME_W-1:0]  victim_frame;
  logic [ECOUNT_W-1:0] entry_count;

  modport source (output valid, victim_valid, victim_frame, entry_count, input ready);
  modport sink   (input valid, victim_valid, victim_frame, entry_count, output ready);
endinterface

>>> hdl/lrufr_ram.sv
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
module lrufr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

>>> hdl/lrufr_cfg.sv
// APB-style register block of the LRU frame replacer: holds the capacity
// register. Depends on lrufr_pkg.
module lrufr_cfg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [lrufr_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [lrufr_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [lrufr_pkg::APB_DATA_W-1:0]  prdata,
  output logic                              pready,
  output logic [lrufr_pkg::CAP_W-1:0]       capacity
);
  import lrufr_pkg::*;

  logic [CAP_W-1:0]     capacity_r;
  logic [CAP_W-1:0]     capacity_nxt;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_fire;

  assign reg_idx = paddr[APB_ADDR_W-1:2];
  assign wr_fire = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_comb begin
    capacity_nxt = capacity_r;
    if (wr_fire && (reg_idx == REG_CAPACITY)) begin
      capacity_nxt = pwdata[CAP_W-1:0];
    end
  end

  assign prdata   = (reg_idx == REG_CAPACITY) ? APB_DATA_W'(capacity_r) : '0;
  assign capacity = capacity_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= CAP_RESET;
    end else begin
      capacity_r <= capacity_nxt;
    end
  end

endmodule

>>> hdl/lrufr_slot_unit.sv
// Shared slot unit: maps a list position to its RAM slot in the circular
// list and compares a read entry with the frame being searched.
// Depends on lrufr_pkg.
module lrufr_slot_unit (
  input  logic [lrufr_pkg::ADDR_W-1:0]  head,
  input  logic [lrufr_pkg::ADDR_W-1:0]  pos,
  input  logic [lrufr_pkg::FRAME_W-1:0] entry,
  input  logic [lrufr_pkg::FRAME_W-1:0] key,
  output logic [lrufr_pkg::ADDR_W-1:0]  slot,
  output logic                          hit
);
  import lrufr_pkg::*;

  logic [ADDR_W:0] sum;

  always_comb begin
    sum = {1'b0, head} + {1'b0, pos};
    if (sum >= (ADDR_W + 1)'(NUM_FRAMES)) begin
      sum = sum - (ADDR_W + 1)'(NUM_FRAMES);
    end
  end

  assign slot = sum[ADDR_W-1:0];
  assign hit  = (entry == key);

endmodule

>>> hdl/lru_frame_replacer.sv
// LRU frame replacer. Keeps the evictable frames as a circular list in a
// RAM (head = most recent) plus one listed flag per frame in flip-flops.
// Unpin, size queries and ignored commands finish in the cycle the command
// is taken; victim does one RAM read of the oldest slot. Pin of a listed
// frame walks the list through the slot unit, one RAM read per cycle,
// closing the gap behind the removed frame. The command channel is ready
// only while the sequencer is idle; a full output register does not stop
// a command being taken, but a result that finds it full waits in S_HOLD.
// Depends on lrufr_pkg, lrufr_if, lrufr_ram, lrufr_cfg and lrufr_slot_unit.
module lru_frame_replacer (
  input  logic                             clk,
  input  logic                             rst_n,
  lrufr_in_if.sink                         in_chan,
  lrufr_out_if.source                      out_chan,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [lrufr_pkg::APB_ADDR_W-1:0] cfg_paddr,
  input  logic [lrufr_pkg::APB_DATA_W-1:0] cfg_pwdata,
  output logic [lrufr_pkg::APB_DATA_W-1:0] cfg_prdata,
  output logic                             cfg_pready
);
  import lrufr_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_VREAD,
    S_PSCAN,
    S_HOLD
  } state_t;

  state_t                state_r, state_nxt;
  logic [ADDR_W-1:0]     head_r, head_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [NUM_FRAMES-1:0] listed_r, listed_nxt;
  logic [FRAME_W-1:0]    frame_r, frame_nxt;
  logic [CNT_W-1:0]      rd_i_r, rd_i_nxt;
  logic                  pend_r, pend_nxt;
  logic [CNT_W-1:0]      pend_i_r, pend_i_nxt;
  logic [ADDR_W-1:0]     pend_slot_r, pend_slot_nxt;
  logic [ADDR_W-1:0]     prev_slot_r, prev_slot_nxt;
  logic                  found_r, found_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_vv_r, out_vv_nxt;
  logic [FRAME_W-1:0]    out_vf_r, out_vf_nxt;
  logic [ECOUNT_W-1:0]   out_cnt_r, out_cnt_nxt;
  logic                  hold_vv_r, hold_vv_nxt;
  logic [FRAME_W-1:0]    hold_vf_r, hold_vf_nxt;
  logic [ECOUNT_W-1:0]   hold_cnt_r, hold_cnt_nxt;

  logic [CAP_W-1:0]   capacity;
  logic [CNT_W-1:0]   cap_eff;
  logic               in_fire;
  logic               out_free;
  cmd_t               cmd;
  logic               frame_ok;
  logic [ADDR_W-1:0]  fidx;
  logic               fin;
  logic               res_vv;
  logic [FRAME_W-1:0] res_vf;

  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [FRAME_W-1:0] ram_wdata;
  logic               ram_re;
  logic [FRAME_W-1:0] ram_rdata;

  logic [ADDR_W-1:0]  unit_pos;
  logic [ADDR_W-1:0]  unit_slot;
  logic               unit_hit;

  lrufr_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (cfg_psel),
    .penable  (cfg_penable),
    .pwrite   (cfg_pwrite),
    .paddr    (cfg_paddr),
    .pwdata   (cfg_pwdata),
    .prdata   (cfg_prdata),
    .pready   (cfg_pready),
    .capacity (capacity)
  );

  lrufr_ram #(
    .WIDTH (FRAME_W),
    .DEPTH (NUM_FRAMES)
  ) u_order_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (unit_slot),
    .rd_data (ram_rdata)
  );

  lrufr_slot_unit u_slot (
    .head  (head_r),
    .pos   (unit_pos),
    .entry (ram_rdata),
    .key   (frame_r),
    .slot  (unit_slot),
    .hit   (unit_hit)
  );

  assign in_chan.ready = (state_r == S_IDLE);
  assign in_fire       = in_chan.valid && (state_r == S_IDLE);
  assign out_free      = !out_valid_r || out_chan.ready;
  assign cmd           = cmd_t'(in_chan.command);
  assign frame_ok      = (32'(in_chan.frame_index) < NUM_FRAMES);
  assign fidx          = ADDR_W'(in_chan.frame_index);
  assign cap_eff       = (32'(capacity) < NUM_FRAMES) ? CNT_W'(capacity)
                                                       : CNT_W'(NUM_FRAMES);

  assign out_chan.valid        = out_valid_r;
  assign out_chan.victim_valid = out_vv_r;
  assign out_chan.victim_frame = out_vf_r;
  assign out_chan.entry_count  = out_cnt_r;

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    count_nxt     = count_r;
    listed_nxt    = listed_r;
    frame_nxt     = frame_r;
    rd_i_nxt      = rd_i_r;
    pend_nxt      = pend_r;
    pend_i_nxt    = pend_i_r;
    pend_slot_nxt = pend_slot_r;
    prev_slot_nxt = prev_slot_r;
    found_nxt     = found_r;
    hold_vv_nxt   = hold_vv_r;
    hold_vf_nxt   = hold_vf_r;
    hold_cnt_nxt  = hold_cnt_r;
    out_valid_nxt = out_valid_r;
    out_vv_nxt    = out_vv_r;
    out_vf_nxt    = out_vf_r;
    out_cnt_nxt   = out_cnt_r;
    ram_we        = 1'b0;
    ram_waddr     = head_r;
    ram_wdata     = in_chan.frame_index;
    ram_re        = 1'b0;
    unit_pos      = ADDR_W'(rd_i_r);
    fin           = 1'b0;
    res_vv        = 1'b0;
    res_vf        = '0;

    // The output register drains as soon as the sink takes the transfer.
    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          frame_nxt = in_chan.frame_index;
          unique case (cmd)
            CMD_VICTIM: begin
              if (count_r != '0) begin
                unit_pos  = ADDR_W'(count_r - 1'b1);
                ram_re    = 1'b1;
                state_nxt = S_VREAD;
              end else begin
                fin = 1'b1;
              end
            end
            CMD_PIN: begin
              if (frame_ok && listed_r[fidx]) begin
                rd_i_nxt  = '0;
                pend_nxt  = 1'b0;
                found_nxt = 1'b0;
                state_nxt = S_PSCAN;
              end else begin
                fin = 1'b1;
              end
            end
            CMD_UNPIN: begin
              if (frame_ok && !listed_r[fidx] && (count_r < cap_eff)) begin
                head_nxt = (head_r == '0) ? ADDR_W'(NUM_FRAMES - 1) : head_r - 1'b1;
                ram_we           = 1'b1;
                ram_waddr        = head_nxt;
                listed_nxt[fidx] = 1'b1;
                count_nxt        = count_r + 1'b1;
              end
              fin = 1'b1;
            end
            CMD_SIZE: begin
              fin = 1'b1;
            end
          endcase
        end
      end

      S_VREAD: begin
        listed_nxt[ADDR_W'(ram_rdata)] = 1'b0;
        count_nxt = count_r - 1'b1;
        res_vv    = 1'b1;
        res_vf    = ram_rdata;
        fin       = 1'b1;
      end

      S_PSCAN: begin
        // Read side: one list position per cycle, oldest last.
        if (rd_i_r < count_r) begin
          unit_pos      = ADDR_W'(rd_i_r);
          ram_re        = 1'b1;
          rd_i_nxt      = rd_i_r + 1'b1;
          pend_nxt      = 1'b1;
          pend_i_nxt    = rd_i_r;
          pend_slot_nxt = unit_slot;
        end else begin
          pend_nxt = 1'b0;
        end
        // Entries behind the pinned frame move one position toward the head.
        if (pend_r) begin
          if (found_r) begin
            ram_we    = 1'b1;
            ram_waddr = prev_slot_r;
            ram_wdata = ram_rdata;
          end else if (unit_hit) begin
            found_nxt = 1'b1;
          end
          prev_slot_nxt = pend_slot_r;
          if (pend_i_r == count_r - 1'b1) begin
            listed_nxt[ADDR_W'(frame_r)] = 1'b0;
            count_nxt = count_r - 1'b1;
            pend_nxt  = 1'b0;
            fin       = 1'b1;
          end
        end
      end

      S_HOLD: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_vv_nxt    = hold_vv_r;
          out_vf_nxt    = hold_vf_r;
          out_cnt_nxt   = hold_cnt_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (fin) begin
      if (out_free) begin
        out_valid_nxt = 1'b1;
        out_vv_nxt    = res_vv;
        out_vf_nxt    = res_vf;
        out_cnt_nxt   = ECOUNT_W'(count_nxt);
        state_nxt     = S_IDLE;
      end else begin
        hold_vv_nxt  = res_vv;
        hold_vf_nxt  = res_vf;
        hold_cnt_nxt = ECOUNT_W'(count_nxt);
        state_nxt    = S_HOLD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      listed_r    <= '0;
      pend_r      <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      listed_r    <= listed_nxt;
      pend_r      <= pend_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
    frame_r     <= frame_nxt;
    rd_i_r      <= rd_i_nxt;
    pend_i_r    <= pend_i_nxt;
    pend_slot_r <= pend_slot_nxt;
    prev_slot_r <= prev_slot_nxt;
    hold_vv_r   <= hold_vv_nxt;
    hold_vf_r   <= hold_vf_nxt;
    hold_cnt_r  <= hold_cnt_nxt;
    out_vv_r    <= out_vv_nxt;
    out_vf_r    <= out_vf_nxt;
    out_cnt_r   <= out_cnt_nxt;
  end

  // The list never holds more entries than there are frames.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(NUM_FRAMES))
    else $error("entry count exceeds the number of frames");

  // Between commands, the listed flags agree with the entry count.
  a_flags_match_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> ($countones(listed_r) == 32'(count_r)))
    else $error("listed flags disagree with entry count");

  // A pin walk only starts on a listed frame, so the list is not empty.
  a_scan_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PSCAN) |-> (count_r != '0))
    else $error("pin walk over an empty list");

  // A victim read always returns a result with a removed frame.
  a_victim_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_VREAD) |=> (out_valid_r && out_vv_r) || (state_r == S_HOLD && hold_vv_r))
    else $error("victim read produced no victim result");

endmodule

>>> bench/tb_lru_frame_replacer.sv
// Self-checking testbench for lru_frame_replacer: directed and random commands
// over valid/ready channels, capacity set over the APB port, results scored.
// Depends on lrufr_pkg, lrufr_if and the RTL of lru_frame_replacer.
module tb_lru_frame_replacer;
  timeunit 1ns;
  timeprecision 1ps;
  import lrufr_pkg::*;

  localparam int CYCLE_LIMIT = 800_000;
  localparam int DRAIN_CYCLES = NUM_FRAMES + 8;
  localparam logic [APB_ADDR_W-1:0] CAP_ADDR = APB_ADDR_W'(REG_CAPACITY) << 2;

  typedef struct packed {
    logic                victim_valid;
    logic [FRAME_W-1:0]  victim_frame;
    logic [ECOUNT_W-1:0] entry_count;
  } lru_result_t;

  // Tracks the recency list and scores every result against it.
  class replacer_scoreboard;
    logic [FRAME_W-1:0] lru_order[$];   // front is the most recent frame
    bit                 is_listed[NUM_FRAMES];
    logic [CAP_W-1:0]   capacity = CAP_RESET;
    lru_result_t        pending_results[$];
    int fails = 0;
    int commands = 0;
    int checked = 0;
    int victims = 0;
    int peak = 0;

    function void note_command(cmd_t cmd, logic [FRAME_W-1:0] frame);
      lru_result_t r;
      int limit;
      int pos;
      r = '0;
      limit = (capacity > NUM_FRAMES) ? NUM_FRAMES : int'(capacity);
      pos = -1;
      case (cmd)
        CMD_VICTIM: if (lru_order.size() > 0) begin
          r.victim_frame = lru_order[$];
          lru_order.delete(lru_order.size() - 1);
          r.victim_valid = 1'b1;
          is_listed[r.victim_frame] = 1'b0;
          victims++;
        end
        CMD_PIN: if (is_listed[frame]) begin
          for (int i = 0; i < lru_order.size(); i++)
            if (lru_order[i] == frame && pos < 0) pos = i;
          if (pos >= 0) lru_order.delete(pos);
          is_listed[frame] = 1'b0;
        end
        CMD_UNPIN: if (!is_listed[frame] && lru_order.size() < limit) begin
          lru_order.insert(0, frame);
          is_listed[frame] = 1'b1;
        end
        default: ;
      endcase
      r.entry_count = ECOUNT_W'(lru_order.size());
      if (lru_order.size() > peak) peak = lru_order.size();
      pending_results.push_back(r);
      commands++;
    endfunction

    function void compare_field(string name, int exp_val, int got_val);
      if (exp_val != got_val) begin
        $error("%s: expected %0d, got %0d", name, exp_val, got_val);
        fails++;
      end
    endfunction

    function void check_result(logic vv, logic [FRAME_W-1:0] vf, logic [ECOUNT_W-1:0] ec);
      lru_result_t e;
      if (pending_results.size() == 0) begin
        if (fails < 30) $error("result transfer with no command outstanding");
        fails++;
        return;
      end
      e = pending_results.pop_front();
      compare_field("victim_valid", e.victim_valid, vv);
      compare_field("victim_frame", e.victim_frame, vf);
      compare_field("entry_count", e.entry_count, ec);
      checked++;
    endfunction

    // First unlisted frame at or after start, wrapping; start if all are listed.
    function logic [FRAME_W-1:0] first_unlisted(logic [FRAME_W-1:0] start);
      for (int i = 0; i < NUM_FRAMES; i++)
        if (!is_listed[(start + i) % NUM_FRAMES]) return FRAME_W'((start + i) % NUM_FRAMES);
      return start;
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [APB_ADDR_W-1:0] cfg_paddr;
  logic [APB_DATA_W-1:0] cfg_pwdata;
  logic [APB_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;
  bit no_idle = 1'b0;
  int cycles = 0;
  int cap_settings = 0;
  replacer_scoreboard sb = new();

  lrufr_in_if  in_if();
  lrufr_out_if out_if();

  lru_frame_replacer u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_if),
    .out_chan   (out_if),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Result side: random back-pressure, scored at the rising edge.
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_if.ready <= no_idle || ($urandom_range(0, 99) >= 21);
    end
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1)
      sb.check_result(out_if.victim_valid, out_if.victim_frame, out_if.entry_count);
  end

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_item(input cmd_t cmd, input logic [FRAME_W-1:0] frame);
    while (!no_idle && $urandom_range(0, 99) < 21) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.command     <= cmd;
    in_if.frame_index <= frame;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    sb.note_command(cmd, frame);
    @(negedge clk);
  endtask

  task automatic cfg_access(input logic wr, input logic [APB_DATA_W-1:0] wdata,
                            output logic [APB_DATA_W-1:0] rdata);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= CAP_ADDR;
    cfg_pwdata  <= wdata;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (cfg_pready !== 1'b1);
    rdata = cfg_prdata;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  // Waits for the block to go idle, writes the capacity and reads it back.
  task automatic set_capacity(input logic [CAP_W-1:0] cap);
    logic [APB_DATA_W-1:0] rd;
    in_if.valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(negedge clk);
    cfg_access(1'b1, APB_DATA_W'(cap), rd);
    sb.capacity = cap;
    cap_settings++;
    cfg_access(1'b0, '0, rd);
    if (rd !== APB_DATA_W'(cap)) begin
      $error("capacity readback: expected %0d, got %0d", cap, rd);
      sb.fails++;
    end
  endtask

  task automatic run_phase(input logic [CAP_W-1:0] cap, input int n, input int w_victim,
                           input int w_pin, input int w_unpin, input bit quiet);
    int pick;
    cmd_t cmd;
    logic [FRAME_W-1:0] frame;
    set_capacity(cap);
    no_idle = quiet;
    for (int k = 0; k < n; k++) begin
      pick  = $urandom_range(0, 99);
      frame = FRAME_W'($urandom_range(0, NUM_FRAMES - 1));
      if (pick < w_victim) cmd = CMD_VICTIM;
      else if (pick < w_victim + w_pin) cmd = CMD_PIN;
      else if (pick < w_victim + w_pin + w_unpin) cmd = CMD_UNPIN;
      else cmd = CMD_SIZE;
      // Bias pins toward listed frames and unpins toward unlisted ones so
      // that both commands mostly take effect.
      if (cmd == CMD_PIN && sb.lru_order.size() > 0 && $urandom_range(0, 3) != 0)
        frame = sb.lru_order[$urandom_range(0, sb.lru_order.size() - 1)];
      else if (cmd == CMD_UNPIN && $urandom_range(0, 9) < 7)
        frame = sb.first_unlisted(frame);
      send_item(cmd, frame);
    end
    no_idle = 1'b0;
  endtask

  initial begin
    rst_n             = 1'b0;
    in_if.valid       = 1'b0;
    in_if.command     = CMD_SIZE;
    in_if.frame_index = '0;
    cfg_psel          = 1'b0;
    cfg_penable       = 1'b0;
    cfg_pwrite        = 1'b0;
    cfg_paddr         = '0;
    cfg_pwdata        = '0;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    // Directed: empty list, ignored pins and unpins, removal from the middle.
    send_item(CMD_VICTIM, 6'd0);
    send_item(CMD_SIZE, 6'd63);
    send_item(CMD_PIN, 6'd7);
    send_item(CMD_UNPIN, 6'd0);
    send_item(CMD_UNPIN, 6'd63);
    send_item(CMD_UNPIN, 6'd0);
    send_item(CMD_UNPIN, 6'd42);
    send_item(CMD_SIZE, 6'd0);
    send_item(CMD_PIN, 6'd63);
    send_item(CMD_PIN, 6'd63);
    send_item(CMD_VICTIM, 6'd63);
    send_item(CMD_VICTIM, 6'd0);
    send_item(CMD_VICTIM, 6'd0);
    send_item(CMD_UNPIN, 6'd21);
    send_item(CMD_PIN, 6'd21);
    // Zero capacity rejects every unpin; a capacity of one fills at once.
    set_capacity(7'd0);
    send_item(CMD_UNPIN, 6'd9);
    send_item(CMD_SIZE, 6'd0);
    set_capacity(7'd1);
    send_item(CMD_UNPIN, 6'd5);
    send_item(CMD_UNPIN, 6'd6);
    send_item(CMD_PIN, 6'd5);
    send_item(CMD_UNPIN, 6'd6);
    send_item(CMD_VICTIM, 6'd0);

    // Random: run with the capacity at the full 64 entries, then shrink the
    // capacity below the current count, and drain at the end.
    run_phase(7'd64, 400, 15, 20, 60, 1'b0);
    run_phase(7'd127, 250, 25, 25, 45, 1'b1);
    run_phase(7'd5, 250, 20, 25, 50, 1'b0);
    run_phase(7'd0, 150, 30, 20, 40, 1'b0);
    run_phase(7'd33, 300, 20, 25, 50, 1'b0);
    run_phase(7'd1, 150, 30, 20, 45, 1'b0);
    run_phase(7'd64, 150, 45, 20, 30, 1'b0);

    in_if.valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Covered %0d commands and %0d results, %0d victims returned,",
             sb.commands, sb.checked, sb.victims);
    $display("list depth up to %0d entries over %0d capacity settings.",
             sb.peak, cap_settings);
    if (sb.fails == 0 && sb.pending_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
